[sv/assert_macros.svh]
// shared assertion macros, clocked on i_clk and masked during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define RTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// trigger in this cycle, consequence in the next
`define RTI_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[sv/rti_pkg.sv]
`timescale 1ns / 1ps
package rti_pkg;

    localparam int AXIS_POINTS = 32;
    localparam int AXIS_BITS   = $clog2(AXIS_POINTS);
    localparam int CNT_BITS    = $clog2(AXIS_POINTS + 1);
    localparam int SMP_ADDR_W  = 3 * AXIS_BITS;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 15;
    localparam int OP_W        = 3;
    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_LOAD_X = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_Y = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_Z = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD_S = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_X_POINTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_POINTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_POINTS = 2'd2;

    typedef enum logic [2:0] {
        K_X,
        K_Y,
        K_Z,
        K_S,
        K_Q
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [IDX_W-1:0]         addr;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] qx;
        logic signed [DATA_W-1:0] qy;
        logic signed [DATA_W-1:0] qz;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] x;
        logic [CFG_W-1:0] y;
        logic [CFG_W-1:0] z;
    } t_points;

endpackage

[sv/rectilinear_trilinear_interpolator.sv]
`timescale 1ns / 1ps
// rectilinear trilinear interpolator
// input channel (i_in_valid / o_in_stall) takes one word per item: opcode 0..2 load
// an axis coordinate, 3 loads a sample at flat index (z*32+y)*32+x, 4 is a query.
// loads, unknown opcodes and out-of-range loads give no result; a query gives
// one word on the output channel (o_out_valid / i_out_stall).
// items pass through a two-entry queue; the sender sees a stall only while it is full.
// a load is written to its store as it is popped; a query runs a
// linear scan of all three coordinate banks in parallel, one setup state,
// restoring division (six lanes) for 16 quotient bits, 14 multiply-accumulate terms
// each through read, multiply and accumulate states on one multiplier and the
// single-port sample memory, then a state that loads the output register.
// items are worked one at a time, in order.
// reset clears the control state and sets all point counts to 32; the stores
// keep their contents and must be loaded before they are read.
// a stalled output word holds; the block finishes the next query and waits
// with it until the output register frees, and the queue then backs up.
// configuration (i_cfg_we/idx/data) sets the point counts, 0 held as 1, above 32
// held as 32. the user must write it only while the block is idle; the block does not enforce this.
module rectilinear_trilinear_interpolator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [rti_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [rti_pkg::OP_W-1:0]             i_opcode,
    input  logic [rti_pkg::IDX_W-1:0]            i_load_index,
    input  logic signed [rti_pkg::DATA_W-1:0]    i_load_value,
    input  logic signed [rti_pkg::DATA_W-1:0]    i_query_x,
    input  logic signed [rti_pkg::DATA_W-1:0]    i_query_y,
    input  logic signed [rti_pkg::DATA_W-1:0]    i_query_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [rti_pkg::DATA_W-1:0]    o_interp_value
);

    localparam logic [rti_pkg::CFG_W-1:0] PTS_MAX = rti_pkg::CFG_W'(rti_pkg::AXIS_POINTS);

    rti_pkg::t_points        r_points;
    logic [rti_pkg::CFG_W-1:0] w_clamped;
    logic                    w_push;
    logic                    w_full;
    logic                    w_pop;
    logic                    w_q_valid;
    rti_pkg::t_item          w_in_item;
    rti_pkg::t_item          w_q_item;

    assign w_clamped = (i_cfg_data == '0) ? rti_pkg::CFG_W'(1) :
                       ((i_cfg_data > PTS_MAX) ? PTS_MAX : i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points.x <= PTS_MAX;
            r_points.y <= PTS_MAX;
            r_points.z <= PTS_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rti_pkg::CFG_X_POINTS: r_points.x <= w_clamped;
                rti_pkg::CFG_Y_POINTS: r_points.y <= w_clamped;
                rti_pkg::CFG_Z_POINTS: r_points.z <= w_clamped;
                default: ;
            endcase
        end
    end

    rti_front u_front (
        .i_in_valid   (i_in_valid),
        .i_opcode     (i_opcode),
        .i_load_index (i_load_index),
        .i_load_value (i_load_value),
        .i_query_x    (i_query_x),
        .i_query_y    (i_query_y),
        .i_query_z    (i_query_z),
        .i_full       (w_full),
        .o_in_stall   (o_in_stall),
        .o_push       (w_push),
        .o_item       (w_in_item)
    );

    rti_queue #(
        .DEPTH (rti_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    rti_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_points       (r_points),
        .i_item_valid   (w_q_valid),
        .i_item         (w_q_item),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_interp_value (o_interp_value)
    );

endmodule

[sv/rti_front.sv]
`timescale 1ns / 1ps
module rti_front (
    input  logic                              i_in_valid,
    input  logic [rti_pkg::OP_W-1:0]          i_opcode,
    input  logic [rti_pkg::IDX_W-1:0]         i_load_index,
    input  logic signed [rti_pkg::DATA_W-1:0] i_load_value,
    input  logic signed [rti_pkg::DATA_W-1:0] i_query_x,
    input  logic signed [rti_pkg::DATA_W-1:0] i_query_y,
    input  logic signed [rti_pkg::DATA_W-1:0] i_query_z,
    input  logic                              i_full,
    output logic                              o_in_stall,
    output logic                              o_push,
    output rti_pkg::t_item                    o_item
);

    logic w_keep;
    logic w_axis_ok;
    logic w_smp_ok;

    assign w_axis_ok = (i_load_index >> rti_pkg::AXIS_BITS) == '0;
    assign w_smp_ok  = (i_load_index >> rti_pkg::SMP_ADDR_W) == '0;

    // unknown opcodes and out-of-range loads are taken and dropped here
    always_comb begin
        o_item.addr  = i_load_index;
        o_item.value = i_load_value;
        o_item.qx    = i_query_x;
        o_item.qy    = i_query_y;
        o_item.qz    = i_query_z;
        unique case (i_opcode)
            rti_pkg::OP_LOAD_X: begin
                o_item.kind = rti_pkg::K_X;
                w_keep      = w_axis_ok;
            end
            rti_pkg::OP_LOAD_Y: begin
                o_item.kind = rti_pkg::K_Y;
                w_keep      = w_axis_ok;
            end
            rti_pkg::OP_LOAD_Z: begin
                o_item.kind = rti_pkg::K_Z;
                w_keep      = w_axis_ok;
            end
            rti_pkg::OP_LOAD_S: begin
                o_item.kind = rti_pkg::K_S;
                w_keep      = w_smp_ok;
            end
            rti_pkg::OP_QUERY: begin
                o_item.kind = rti_pkg::K_Q;
                w_keep      = 1'b1;
            end
            default: begin
                o_item.kind = rti_pkg::K_Q;
                w_keep      = 1'b0;
            end
        endcase
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full && w_keep;

endmodule

[sv/rti_queue.sv]
`timescale 1ns / 1ps
module rti_queue #(
    parameter int DEPTH = rti_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rti_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output rti_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rti_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

endmodule

[sv/rti_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rti_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rti_pkg::t_points                  i_points,
    input  logic                              i_item_valid,
    input  rti_pkg::t_item                    i_item,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [rti_pkg::DATA_W-1:0] o_interp_value
);

    localparam int AP     = rti_pkg::AXIS_POINTS;
    localparam int AB     = rti_pkg::AXIS_BITS;
    localparam int CB     = rti_pkg::CNT_BITS;
    localparam int SW     = rti_pkg::SMP_ADDR_W;
    localparam int DW     = rti_pkg::DATA_W;
    localparam int VW     = rti_pkg::VALUE_WIDTH;
    localparam int FB     = rti_pkg::FRAC_BITS;
    localparam int OW     = DW + 2;
    localparam int WW     = FB + 1;
    localparam int PW     = OW + WW + 1;
    localparam int DCW    = $clog2(FB);
    localparam int TERMS  = 14;
    localparam int TERM_W = $clog2(TERMS);

    localparam logic signed [OW-1:0] VMAX = {{(OW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [OW-1:0] VMIN = {{(OW-VW+1){1'b1}}, {(VW-1){1'b0}}};
    localparam logic [WW-1:0]        W_ONE = {1'b1, {FB{1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_DIV,
        S_RD,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [CB-1:0]       r_cnt;
    logic [DCW-1:0]      r_div_cnt;
    logic [TERM_W-1:0]   r_term;
    logic                r_out_valid;
    logic signed [DW-1:0] r_out_data;

    // coordinate banks and sample memory
    logic signed [DW-1:0] r_cmem [3][AP];
    logic signed [DW-1:0] r_crd [3];
    logic [DW-1:0]        r_smem [2**SW];
    logic signed [DW-1:0] r_srd;

    // per-axis search and division state
    logic signed [DW-1:0] r_q [3];
    logic signed [DW-1:0] r_c0 [3];
    logic signed [DW-1:0] r_clast [3];
    logic signed [DW-1:0] r_prev [3];
    logic signed [DW-1:0] r_cu [3];
    logic signed [DW-1:0] r_cl [3];
    logic [AB-1:0]        r_u [3];
    logic                 r_found [3];
    logic                 r_low [3];
    logic                 r_high [3];
    logic [AB-1:0]        r_lo [3];
    logic [AB-1:0]        r_hi [3];
    logic [DW-1:0]        r_rem_lo [3];
    logic [DW-1:0]        r_rem_hi [3];
    logic [DW-1:0]        r_den [3];
    logic [FB-1:0]        r_quo_lo [3];
    logic [FB-1:0]        r_quo_hi [3];

    // blend datapath
    logic signed [OW-1:0] r_cv [6];
    logic signed [OW-1:0] r_res;
    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] r_acc;

    logic [CB-1:0]        w_n [3];
    logic [CB-1:0]        w_didx;
    logic                 w_dvalid [3];
    logic                 w_is_low [3];
    logic                 w_is_high [3];
    logic [DW:0]          w_sh_lo [3];
    logic [DW:0]          w_sh_hi [3];
    logic                 w_ge_lo [3];
    logic                 w_ge_hi [3];
    logic [DW:0]          w_sub_lo [3];
    logic [DW:0]          w_sub_hi [3];
    logic [DW:0]          w_d_num_lo [3];
    logic [DW:0]          w_d_num_hi [3];
    logic [DW:0]          w_d_den [3];
    logic [WW-1:0]        w_wl [3];
    logic [WW-1:0]        w_wh [3];
    logic [2:0]           w_cwe;
    logic                 w_swe;
    logic [2:0]           w_pair;
    logic                 w_side;
    logic [AB-1:0]        w_ix;
    logic [AB-1:0]        w_iy;
    logic [AB-1:0]        w_iz;
    logic [SW-1:0]        w_saddr;
    logic signed [OW-1:0] w_opnd;
    logic [WW-1:0]        w_wsel;
    logic signed [WW:0]   w_wext;
    logic signed [PW-1:0] w_sum;
    logic signed [PW-1:0] w_shr;
    logic signed [OW-1:0] w_sat;
    logic                 w_start;

    assign w_n[0] = i_points.x;
    assign w_n[1] = i_points.y;
    assign w_n[2] = i_points.z;

    assign o_pop   = (r_state == S_IDLE) && i_item_valid;
    assign w_start = o_pop && (i_item.kind == rti_pkg::K_Q);
    assign w_cwe[0] = o_pop && (i_item.kind == rti_pkg::K_X);
    assign w_cwe[1] = o_pop && (i_item.kind == rti_pkg::K_Y);
    assign w_cwe[2] = o_pop && (i_item.kind == rti_pkg::K_Z);
    assign w_swe    = o_pop && (i_item.kind == rti_pkg::K_S);

    // read data of index r_cnt-1 is present during the scan
    assign w_didx = r_cnt - 1'b1;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_dvalid[a]   = (r_state == S_SCAN) && (r_cnt != '0) && (w_didx < w_n[a]);
            w_is_low[a]   = r_q[a] <= r_c0[a];
            w_is_high[a]  = !w_is_low[a] && (r_q[a] >= r_clast[a]);
            w_d_num_lo[a] = {r_cu[a][DW-1], r_cu[a]} - {r_q[a][DW-1], r_q[a]};
            w_d_num_hi[a] = {r_q[a][DW-1], r_q[a]} - {r_cl[a][DW-1], r_cl[a]};
            w_d_den[a]    = {r_cu[a][DW-1], r_cu[a]} - {r_cl[a][DW-1], r_cl[a]};
            w_sh_lo[a]    = {r_rem_lo[a], 1'b0};
            w_sh_hi[a]    = {r_rem_hi[a], 1'b0};
            w_ge_lo[a]    = w_sh_lo[a] >= {1'b0, r_den[a]};
            w_ge_hi[a]    = w_sh_hi[a] >= {1'b0, r_den[a]};
            w_sub_lo[a]   = w_sh_lo[a] - {1'b0, r_den[a]};
            w_sub_hi[a]   = w_sh_hi[a] - {1'b0, r_den[a]};
            if (r_low[a]) begin
                w_wl[a] = W_ONE;
                w_wh[a] = '0;
            end else if (r_high[a]) begin
                w_wl[a] = '0;
                w_wh[a] = W_ONE;
            end else begin
                w_wl[a] = {1'b0, r_quo_lo[a]};
                w_wh[a] = {1'b0, r_quo_hi[a]};
            end
        end
    end

    // term pairs 0..3 blend along x, 4..5 along y, 6 along z
    assign w_pair  = r_term[TERM_W-1:1];
    assign w_side  = r_term[0];
    assign w_ix    = w_side ? r_hi[0] : r_lo[0];
    assign w_iy    = w_pair[1] ? r_hi[1] : r_lo[1];
    assign w_iz    = w_pair[0] ? r_hi[2] : r_lo[2];
    assign w_saddr = {w_iz, w_iy, w_ix};

    always_comb begin
        unique case (w_pair)
            3'd0, 3'd1, 3'd2, 3'd3: begin
                w_opnd = {{(OW-DW){r_srd[DW-1]}}, r_srd};
                w_wsel = w_side ? w_wh[0] : w_wl[0];
            end
            3'd4: begin
                w_opnd = w_side ? r_cv[2] : r_cv[0];
                w_wsel = w_side ? w_wh[1] : w_wl[1];
            end
            3'd5: begin
                w_opnd = w_side ? r_cv[3] : r_cv[1];
                w_wsel = w_side ? w_wh[1] : w_wl[1];
            end
            3'd6: begin
                w_opnd = w_side ? r_cv[5] : r_cv[4];
                w_wsel = w_side ? w_wh[2] : w_wl[2];
            end
            default: begin
                w_opnd = '0;
                w_wsel = '0;
            end
        endcase
    end

    assign w_wext = {1'b0, w_wsel};
    assign w_sum  = r_acc + r_prod;
    assign w_shr  = w_sum >>> FB;
    assign w_sat  = (r_res > VMAX) ? VMAX : ((r_res < VMIN) ? VMIN : r_res);

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            if (w_cwe[a]) begin
                r_cmem[a][i_item.addr[AB-1:0]] <= i_item.value;
            end
            r_crd[a] <= r_cmem[a][r_cnt[AB-1:0]];
        end
        if (w_swe) begin
            r_smem[i_item.addr[SW-1:0]] <= i_item.value;
        end
        r_srd <= r_smem[w_saddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_q[0] <= i_item.qx;
            r_q[1] <= i_item.qy;
            r_q[2] <= i_item.qz;
        end
        for (int a = 0; a < 3; a++) begin
            if (r_state == S_IDLE) begin
                r_found[a] <= 1'b0;
            end else if (w_dvalid[a]) begin
                r_prev[a] <= r_crd[a];
                if (w_didx == '0) begin
                    r_c0[a] <= r_crd[a];
                end
                if (w_didx == w_n[a] - 1'b1) begin
                    r_clast[a] <= r_crd[a];
                end
                // first in-use coordinate above the point, by position
                if (w_didx != '0 && !r_found[a] && r_crd[a] > r_q[a]) begin
                    r_found[a] <= 1'b1;
                    r_u[a]     <= w_didx[AB-1:0];
                    r_cu[a]    <= r_crd[a];
                    r_cl[a]    <= r_prev[a];
                end
            end
            if (r_state == S_PREP) begin
                r_low[a]    <= w_is_low[a];
                r_high[a]   <= w_is_high[a];
                r_quo_lo[a] <= '0;
                r_quo_hi[a] <= '0;
                if (w_is_low[a]) begin
                    r_lo[a] <= '0;
                    r_hi[a] <= '0;
                end else if (w_is_high[a]) begin
                    r_lo[a] <= AB'(w_n[a] - 1'b1);
                    r_hi[a] <= AB'(w_n[a] - 1'b1);
                end else begin
                    r_lo[a] <= r_u[a] - 1'b1;
                    r_hi[a] <= r_u[a];
                end
                if (w_is_low[a] || w_is_high[a]) begin
                    r_rem_lo[a] <= '0;
                    r_rem_hi[a] <= '0;
                    r_den[a]    <= DW'(1);
                end else begin
                    r_rem_lo[a] <= w_d_num_lo[a][DW-1:0];
                    r_rem_hi[a] <= w_d_num_hi[a][DW-1:0];
                    r_den[a]    <= w_d_den[a][DW-1:0];
                end
            end else if (r_state == S_DIV) begin
                r_rem_lo[a] <= w_ge_lo[a] ? w_sub_lo[a][DW-1:0] : w_sh_lo[a][DW-1:0];
                r_rem_hi[a] <= w_ge_hi[a] ? w_sub_hi[a][DW-1:0] : w_sh_hi[a][DW-1:0];
                r_quo_lo[a] <= {r_quo_lo[a][FB-2:0], w_ge_lo[a]};
                r_quo_hi[a] <= {r_quo_hi[a][FB-2:0], w_ge_hi[a]};
            end
        end
        if (r_state == S_MUL) begin
            r_prod <= w_opnd * w_wext;
        end
        if (r_state == S_ACC) begin
            if (!w_side) begin
                r_acc <= r_prod;
            end else if (w_pair == 3'd6) begin
                r_res <= OW'(w_shr);
            end else begin
                r_cv[w_pair] <= OW'(w_shr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_div_cnt   <= '0;
            r_term      <= '0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (w_start) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CB'(AP)) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_div_cnt <= '0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DCW'(FB - 1)) begin
                        r_term  <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_term == TERM_W'(TERMS - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_term  <= r_term + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= w_sat[DW-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_interp_value = r_out_data;

    // the lower numerator equals the width when the point sits on the lower coordinate
    `RTI_ASSERT(a_out_from_seq, $rose(r_out_valid) |-> $past(r_state == S_OUT), "word without a finished blend")
    `RTI_ASSERT(a_div_rem, (r_state == S_DIV) |-> (r_rem_lo[0] <= r_den[0]) && (r_rem_hi[0] < r_den[0]), "x remainder above width")
    `RTI_ASSERT_NEXT(a_last_term, (r_state == S_ACC) && (r_term == TERM_W'(TERMS - 1)), r_state == S_OUT, "blend did not finish")

endmodule

[dv/rectilinear_trilinear_interpolator_tb.sv]
`timescale 1ns / 1ps
module rectilinear_trilinear_interpolator_tb;
    import rti_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 150;
    localparam int SMP_DEPTH = AXIS_POINTS * AXIS_POINTS * AXIS_POINTS;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] qx;
        logic signed [DATA_W-1:0] qy;
        logic signed [DATA_W-1:0] qz;
        bit                       has_exp;
        logic signed [DATA_W-1:0] exp_val;
    } word_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [CFG_W-1:0]         i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [OP_W-1:0]          i_opcode = '0;
    logic [IDX_W-1:0]         i_load_index = '0;
    logic signed [DATA_W-1:0] i_load_value = '0;
    logic signed [DATA_W-1:0] i_query_x = '0;
    logic signed [DATA_W-1:0] i_query_y = '0;
    logic signed [DATA_W-1:0] i_query_z = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_interp_value;

    rectilinear_trilinear_interpolator uut (.*);

    always #5 i_clk = ~i_clk;

    // mirror of the block's state
    longint                   axis_coord [3][AXIS_POINTS];
    int                       axis_n [3];
    logic signed [DATA_W-1:0] sample_mem [SMP_DEPTH];
    bit                       sample_set [SMP_DEPTH];

    logic signed [DATA_W-1:0] interp_q [$];
    int errors = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    function automatic longint frac_weight(longint num, longint den);
        longint r;
        longint q;
        r = num;
        q = 0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic void axis_cell(int ax, longint q, output int lo, output int hi,
                                      output longint wl, output longint wh);
        int n;
        int u;
        n = axis_n[ax];
        u = n - 1;
        if (q <= axis_coord[ax][0]) begin
            lo = 0; hi = 0; wl = 1 << FRAC_BITS; wh = 0;
        end else if (q >= axis_coord[ax][n-1]) begin
            lo = n - 1; hi = n - 1; wl = 0; wh = 1 << FRAC_BITS;
        end else begin
            for (int i = n - 1; i >= 0; i--)
                if (axis_coord[ax][i] > q) u = i;
            hi = u;
            lo = u - 1;
            wl = frac_weight(axis_coord[ax][u] - q, axis_coord[ax][u] - axis_coord[ax][u-1]);
            wh = frac_weight(q - axis_coord[ax][u-1], axis_coord[ax][u] - axis_coord[ax][u-1]);
        end
    endfunction

    function automatic longint mix(longint a, longint wa, longint b, longint wb);
        return (a * wa + b * wb) >>> FRAC_BITS;
    endfunction

    function automatic longint smp(int z, int y, int x);
        return longint'(sample_mem[(z * AXIS_POINTS + y) * AXIS_POINTS + x]);
    endfunction

    function automatic logic signed [DATA_W-1:0] interpolate(longint qx, longint qy,
                                                             longint qz);
        int xl, xh, yl, yh, zl, zh;
        longint xwl, xwh, ywl, ywh, zwl, zwh;
        longint c00, c01, c10, c11, c0, c1, r;
        axis_cell(0, qx, xl, xh, xwl, xwh);
        axis_cell(1, qy, yl, yh, ywl, ywh);
        axis_cell(2, qz, zl, zh, zwl, zwh);
        c00 = mix(smp(zl, yl, xl), xwl, smp(zl, yl, xh), xwh);
        c01 = mix(smp(zh, yl, xl), xwl, smp(zh, yl, xh), xwh);
        c10 = mix(smp(zl, yh, xl), xwl, smp(zl, yh, xh), xwh);
        c11 = mix(smp(zh, yh, xl), xwl, smp(zh, yh, xh), xwh);
        c0 = mix(c00, ywl, c10, ywh);
        c1 = mix(c01, ywl, c11, ywh);
        r = mix(c0, zwl, c1, zwh);
        if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
        if (r < -64'sh80000000) r = -64'sh80000000;
        return r[DATA_W-1:0];
    endfunction

    // update the mirror for an accepted word, queue the interpolated value of a query
    function automatic void retire_word(word_t w);
        case (w.op)
            OP_LOAD_X: if (w.idx < AXIS_POINTS) axis_coord[0][w.idx] = longint'(w.val);
            OP_LOAD_Y: if (w.idx < AXIS_POINTS) axis_coord[1][w.idx] = longint'(w.val);
            OP_LOAD_Z: if (w.idx < AXIS_POINTS) axis_coord[2][w.idx] = longint'(w.val);
            OP_LOAD_S: begin
                sample_mem[w.idx] = w.val;
                sample_set[w.idx] = 1;
            end
            OP_QUERY: begin
                if (w.has_exp) interp_q.push_back(w.exp_val);
                else interp_q.push_back(interpolate(w.qx, w.qy, w.qz));
            end
            default: ;
        endcase
    endfunction

    function automatic word_t mk(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                 logic signed [DATA_W-1:0] val,
                                 logic signed [DATA_W-1:0] qx, logic signed [DATA_W-1:0] qy,
                                 logic signed [DATA_W-1:0] qz, bit has_exp,
                                 logic signed [DATA_W-1:0] exp_val);
        word_t w;
        w.op = op; w.idx = idx; w.val = val;
        w.qx = qx; w.qy = qy; w.qz = qz;
        w.has_exp = has_exp; w.exp_val = exp_val;
        return w;
    endfunction

    task automatic send_word(word_t w);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_opcode = w.op;
        i_load_index = w.idx;
        i_load_value = w.val;
        i_query_x = w.qx;
        i_query_y = w.qy;
        i_query_z = w.qz;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        retire_word(w);
    endtask

    task automatic load_word(logic [OP_W-1:0] op, int idx, logic signed [DATA_W-1:0] val);
        send_word(mk(op, idx, val, $urandom, $urandom, $urandom, 0, 0));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (interp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_points(logic [CFG_IDX_W-1:0] idx, int ax, int v);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        axis_n[ax] = (v == 0) ? 1 : (v > AXIS_POINTS) ? AXIS_POINTS : v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_point(int ax);
        int n;
        longint lo, hi, pad, v;
        n = axis_n[ax];
        lo = axis_coord[ax][0];
        hi = lo;
        for (int i = 0; i < n; i++) begin
            if (axis_coord[ax][i] < lo) lo = axis_coord[ax][i];
            if (axis_coord[ax][i] > hi) hi = axis_coord[ax][i];
        end
        case ($urandom_range(9))
            0: return $urandom;
            1, 2: return axis_coord[ax][$urandom_range(n - 1)];
            default: begin
                pad = (hi - lo) / 8 + 1;
                v = lo - pad + longint'($urandom) % (hi - lo + 2 * pad);
                if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
                if (v < -64'sh80000000) v = -64'sh80000000;
                return v[DATA_W-1:0];
            end
        endcase
    endfunction

    function automatic int region_index();
        return ($urandom_range(axis_n[2] - 1) * AXIS_POINTS + $urandom_range(axis_n[1] - 1))
               * AXIS_POINTS + $urandom_range(axis_n[0] - 1);
    endfunction

    task automatic load_axis(int ax, bit sorted);
        logic [OP_W-1:0] op;
        longint base, step;
        op = (ax == 0) ? OP_LOAD_X : (ax == 1) ? OP_LOAD_Y : OP_LOAD_Z;
        base = longint'($urandom_range(1 << 29)) - (1 << 28);
        step = $urandom_range(1 << 22, 1);
        for (int i = 0; i < axis_n[ax]; i++) begin
            if (sorted) load_word(op, i, base + i * step);
            else load_word(op, i, $urandom);
        end
    endtask

    task automatic run_phase(int wx, int wy, int wz, int n_words, bit sorted);
        int k;
        word_t w;
        drain();
        write_points(CFG_X_POINTS, 0, wx);
        write_points(CFG_Y_POINTS, 1, wy);
        write_points(CFG_Z_POINTS, 2, wz);
        for (int ax = 0; ax < 3; ax++) load_axis(ax, sorted);
        // every sample that a query can reach gets written before any query
        for (int z = 0; z < axis_n[2]; z++)
            for (int y = 0; y < axis_n[1]; y++)
                for (int x = 0; x < axis_n[0]; x++) begin
                    k = (z * AXIS_POINTS + y) * AXIS_POINTS + x;
                    if (!sample_set[k] || $urandom_range(3) == 0)
                        load_word(OP_LOAD_S, k, $urandom);
                end
        for (int i = 0; i < n_words; i++) begin
            case ($urandom_range(19))
                0, 1, 2: load_word(OP_LOAD_S, region_index(), $urandom);
                3: load_word(OP_LOAD_S, $urandom_range(SMP_DEPTH - 1), $urandom);
                4: load_word($urandom_range(2), $urandom_range(32767, AXIS_POINTS), $urandom);
                5: send_word(mk($urandom_range(7, 5), $urandom, $urandom, $urandom,
                                $urandom, $urandom, 0, 0));
                default: send_word(mk(OP_QUERY, $urandom, $urandom, pick_point(0),
                                      pick_point(1), pick_point(2), 0, 0));
            endcase
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = ($urandom_range(99) < out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        logic signed [DATA_W-1:0] want;
        if (o_out_valid && !i_out_stall) begin
            if (interp_q.size() == 0) begin
                $error("interp_value: unexpected word %h", o_interp_value);
                errors++;
            end else begin
                want = interp_q.pop_front();
                if (o_interp_value !== want) begin
                    $error("interp_value: expected %h, got %h", want, o_interp_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        word_t dir [$];
        for (int i = 0; i < SMP_DEPTH; i++) begin
            sample_mem[i] = '0;
            sample_set[i] = 0;
        end
        for (int ax = 0; ax < 3; ax++) begin
            axis_n[ax] = AXIS_POINTS;
            for (int i = 0; i < AXIS_POINTS; i++) axis_coord[ax][i] = 0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        in_idle_pct = 32;
        out_idle_pct = 65;
        // single-point grid: every query returns sample 0 unchanged
        write_points(CFG_X_POINTS, 0, 0);
        write_points(CFG_Y_POINTS, 1, 1);
        write_points(CFG_Z_POINTS, 2, 1);
        dir.push_back(mk(OP_LOAD_X, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_LOAD_Y, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_LOAD_Z, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_LOAD_S, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_QUERY, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0, 1, 32'h7FFFFFFF));
        dir.push_back(mk(OP_QUERY, 0, 0, 32'h7FFFFFFF, 32'h80000000, -1, 1, 32'h7FFFFFFF));
        dir.push_back(mk(OP_LOAD_S, 0, 32'h80000000, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 1, 32'h80000000));
        dir.push_back(mk(OP_RSVD_5, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_RSVD_6, 15'h7FFF, -1, -1, -1, -1, 0, 0));
        dir.push_back(mk(OP_RSVD_7, 15'h7FFF, 32'hFFFFFFFF, 0, 0, 0, 0, 0));
        // axis loads past the last entry are dropped
        dir.push_back(mk(OP_LOAD_X, 15'h7FFF, 32'h12345, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_LOAD_Y, AXIS_POINTS, -1, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_LOAD_Z, 15'h7FFF, 32'h7FFFFFFF, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_QUERY, 0, 0, 1, 1, 1, 1, 32'h80000000));
        dir.push_back(mk(OP_LOAD_S, 15'h7FFF, 32'h1234, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_LOAD_S, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_QUERY, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 1, 0));
        dir.push_back(mk(OP_LOAD_S, 0, -1, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_QUERY, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, -1));
        foreach (dir[i]) send_word(dir[i]);

        // all coordinate entries get a value so no later count reads an unwritten one
        drain();
        write_points(CFG_X_POINTS, 0, 63);
        write_points(CFG_Y_POINTS, 1, AXIS_POINTS);
        write_points(CFG_Z_POINTS, 2, 40);
        for (int ax = 0; ax < 3; ax++) load_axis(ax, 1);

        run_phase(63, 1, 1, 170, 1);
        run_phase(1, 32, 0, 170, 1);
        run_phase(2, 3, 4, 170, 1);
        in_idle_pct = 65;
        out_idle_pct = 32;
        run_phase(1, 1, 32, 170, 1);
        run_phase(5, 5, 5, 150, 0);
        in_idle_pct = 0;
        out_idle_pct = 0;
        run_phase(4, 4, 4, 100, 1);
        // long receiver hold-off while the sender keeps offering queries
        hold_req = 1;
        for (int i = 0; i < 12; i++)
            send_word(mk(OP_QUERY, 0, 0, pick_point(0), pick_point(1), pick_point(2), 0, 0));
        run_phase(3, 2, 5, 70, 1);
        drain();
        for (int i = 0; i < 60; i++)
            send_word(mk(OP_QUERY, 0, 0, pick_point(0), pick_point(1), pick_point(2), 0, 0));

        drain();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
